/* hw/rtl/skdrc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the root table of the soft-knee compressor.
package skdrc_pkg;

  localparam int CNT_W = 5;
  localparam int SAMPLE_W = 24;
  localparam int PEAK_W = 23;
  localparam int ENV_W = 24;

  localparam logic signed [17:0] DB_FLOOR_Q88 = -18'sd51200;
  localparam logic [18:0] K_DB_PER_LOG2 = 19'd394566;
  localparam logic [21:0] K_LOG2_PER_DB = 22'd2786635;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_KNEE = 3'd1;
  localparam logic [2:0] REG_SLOPE = 3'd2;
  localparam logic [2:0] REG_ATTACK = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_MAKEUP = 3'd5;

  typedef struct packed {
    logic signed [14:0] threshold_db;
    logic [12:0] knee_width_db;
    logic [15:0] ratio_slope;
    logic [23:0] attack_coefficient;
    logic [23:0] release_coefficient;
    logic signed [13:0] makeup_db;
  } cfg_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic [CNT_W-1:0] count;
  } frame_desc_t;

  typedef logic [30:0] root_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x = x_in;
    res = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Successive roots 2^(2^-k) in Q1.30, k = 1 to 16.
  function automatic root_tab_t root_table();
    root_tab_t t;
    logic [63:0] r;
    r = isqrt64(64'h2000_0000_0000_0000);
    for (int k = 0; k < 16; k++) begin
      t[k] = r[30:0];
      r = isqrt64(r << 30);
    end
    return t;
  endfunction

  localparam root_tab_t EXP_ROOT = root_table();

endpackage

/* hw/rtl/soft_knee_dynamic_range_compressor_unit.sv */
`timescale 1ns / 1ps
// Top level of the soft-knee feed-forward dynamic range compressor.
//
// Samples (signed Q1.23) are taken one per cycle while input ready is high
// and stored in one of two frame banks while the frame peak is tracked. The
// sample marked last closes the frame and places its peak and sample count in
// a two-entry queue; the front end then fills the other bank, so a new frame
// can be collected while the previous one is processed. Input ready falls only
// when both banks hold frames that have not yet been fully emitted. For each
// frame the back end runs a sixteen-step squaring log2 of the peak, the
// soft-knee gain reduction (the soft region uses a restoring divider with a
// thirteen-bit quotient), the attack or release envelope, and a sixteen-step
// root product for the exponential gain, then scales the stored samples one
// at a time. The back end takes a new frame only after the last sample of the
// previous one has entered the output register. Results leave through an
// output register, so the back end keeps working while a result waits to be
// taken. Samples beyond MAX_CHANNELS in one frame are dropped, but a dropped
// last-marked sample still closes the frame.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should only change while no transaction is in flight.
module soft_knee_dynamic_range_compressor_unit #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [23:0] sample_in,
  input  logic frame_last_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [23:0] sample_out,
  output logic frame_last_out,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import skdrc_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  frame_desc_t q_desc;
  frame_desc_t q_head;
  logic rd_bank;
  logic [IDX_W-1:0] rd_idx;
  logic [SAMPLE_W-1:0] rd_data;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db <= -15'sd5120;
      cfg.knee_width_db <= 13'd1536;
      cfg.ratio_slope <= 16'd49152;
      cfg.attack_coefficient <= 24'd69760;
      cfg.release_coefficient <= 24'd3495;
      cfg.makeup_db <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.threshold_db <= cfg_data[14:0];
        REG_KNEE: cfg.knee_width_db <= cfg_data[12:0];
        REG_SLOPE: cfg.ratio_slope <= cfg_data[15:0];
        REG_ATTACK: cfg.attack_coefficient <= cfg_data;
        REG_RELEASE: cfg.release_coefficient <= cfg_data;
        REG_MAKEUP: cfg.makeup_db <= cfg_data[13:0];
        default: cfg <= cfg;
      endcase
    end
  end

  // Front end: bank filling and peak tracking.
  skdrc_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .frame_last_in(frame_last_in),
    .q_full(q_full),
    .q_push(q_push),
    .q_desc(q_desc),
    .rd_bank(rd_bank),
    .rd_idx(rd_idx),
    .rd_data(rd_data)
  );

  // Closed frames wait here until the back end has emitted them.
  skdrc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .desc_in(q_desc),
    .pop(q_pop),
    .valid(q_valid),
    .full(q_full),
    .head(q_head)
  );

  // Back end: gain computation and sample scaling.
  skdrc_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .rd_bank(rd_bank),
    .rd_idx(rd_idx),
    .rd_data(rd_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .frame_last_out(frame_last_out)
  );

endmodule

/* hw/rtl/skdrc_front.sv */
`timescale 1ns / 1ps
// Front end: takes samples, fills the two frame banks and tracks the peak.
module skdrc_front #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [skdrc_pkg::SAMPLE_W-1:0] sample_in,
  input  logic frame_last_in,
  input  logic q_full,
  output logic q_push,
  output skdrc_pkg::frame_desc_t q_desc,
  input  logic rd_bank,
  input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_idx,
  output logic [skdrc_pkg::SAMPLE_W-1:0] rd_data
);
  import skdrc_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FILL_W = $clog2(MAX_CHANNELS + 1);

  logic [SAMPLE_W-1:0] mem [2][MAX_CHANNELS];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [PEAK_W-1:0] peak;
  logic [PEAK_W-1:0] peak_next;
  logic wbank;
  logic accept;
  logic store;
  logic [SAMPLE_W-1:0] abs_s;
  logic [PEAK_W-1:0] mag;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign store = accept && (fill < FILL_W'(MAX_CHANNELS));

  always_comb begin
    abs_s = sample_in[SAMPLE_W-1] ? (~sample_in + 1'b1) : sample_in;
    mag = abs_s[SAMPLE_W-1] ? {PEAK_W{1'b1}} : abs_s[PEAK_W-1:0];
    fill_next = fill;
    peak_next = peak;
    if (store) begin
      fill_next = fill + 1'b1;
      if (mag > peak) begin
        peak_next = mag;
      end
    end
  end

  assign q_push = accept && frame_last_in;
  assign q_desc = '{peak: peak_next, count: CNT_W'(fill_next)};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      peak <= '0;
      wbank <= 1'b0;
    end else if (q_push) begin
      fill <= '0;
      peak <= '0;
      wbank <= !wbank;
    end else begin
      fill <= fill_next;
      peak <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[wbank][fill[IDX_W-1:0]] <= sample_in;
    end
    rd_data <= mem[rd_bank][rd_idx];
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("frame closed while the queue was full");

endmodule

/* hw/rtl/skdrc_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of closed-frame descriptors between front and back.
module skdrc_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  skdrc_pkg::frame_desc_t desc_in,
  input  logic pop,
  output logic valid,
  output logic full,
  output skdrc_pkg::frame_desc_t head
);
  import skdrc_pkg::*;

  frame_desc_t entry [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;

  assign valid = (count != 2'd0);
  assign full = (count == 2'd2);
  assign head = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= desc_in;
    end
  end

endmodule

/* hw/rtl/skdrc_back.sv */
`timescale 1ns / 1ps
// Back end: level, gain computer, envelope, exponential and sample scaling.
module skdrc_back #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic clk,
  input  logic rst,
  input  skdrc_pkg::cfg_t cfg,
  input  logic q_valid,
  input  skdrc_pkg::frame_desc_t q_head,
  output logic q_pop,
  output logic rd_bank,
  output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_idx,
  input  logic [skdrc_pkg::SAMPLE_W-1:0] rd_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [skdrc_pkg::SAMPLE_W-1:0] sample_out,
  output logic frame_last_out
);
  import skdrc_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_LOG   = 15'h0002,
    ST_DBMUL = 15'h0004,
    ST_DB    = 15'h0008,
    ST_GR    = 15'h0010,
    ST_SQ    = 15'h0020,
    ST_DIV   = 15'h0040,
    ST_ENV   = 15'h0080,
    ST_ENV2  = 15'h0100,
    ST_GAIN  = 15'h0200,
    ST_EXPS  = 15'h0400,
    ST_EXP   = 15'h0800,
    ST_RD    = 15'h1000,
    ST_MUL   = 15'h2000,
    ST_OUT   = 15'h4000
  } state_t;

  state_t state;
  logic [3:0] step;
  logic [CNT_W-1:0] idx;
  logic [ENV_W-1:0] env;

  logic peak_zero;
  logic [4:0] k;
  logic [30:0] m;
  logic [15:0] frac;
  logic [39:0] dbprod;
  logic signed [17:0] over;
  logic [13:0] t2;
  logic [29:0] p1;
  logic [44:0] rem;
  logic [44:0] dsh;
  logic [12:0] quot;
  logic [14:0] gr;
  logic up;
  logic [47:0] envprod;
  logic gneg;
  logic [46:0] gprod;
  logic exp_seed;
  logic [15:0] mf;
  logic [6:0] shamt;
  logic [31:0] em;
  logic sneg;
  logic [55:0] sprod;

  logic [4:0] k_c;
  logic [30:0] m_init;
  logic [61:0] sq;
  logic [31:0] sqs;
  logic [20:0] neg_c;
  logic [16:0] dbr;
  logic signed [17:0] db_c;
  logic signed [18:0] tw;
  logic signed [18:0] kn;
  logic in_knee;
  logic hard;
  logic [32:0] hard_prod;
  logic [14:0] gr_hard;
  logic [ENV_W-1:0] gr8;
  logic up_c;
  logic [ENV_W-1:0] diff_c;
  logic [ENV_W-1:0] delta;
  logic signed [25:0] g;
  logic [24:0] gmag;
  logic [22:0] magr;
  logic signed [23:0] e;
  logic signed [8:0] shift_c;
  logic [62:0] exp_prod;
  logic [31:0] exp_next;
  logic [23:0] av;
  logic [63:0] round_sum;
  logic [63:0] qv;
  logic [23:0] res;
  logic load;
  logic last;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < PEAK_W; i++) begin
      if (q_head.peak[i]) begin
        k_c = 5'(i);
      end
    end
  end

  assign m_init = 31'(q_head.peak) << (5'd30 - k_c);
  assign sq = {31'b0, m} * {31'b0, m};
  assign sqs = sq[61:30];
  assign neg_c = {5'd23 - k, 16'b0} - {5'b0, frac};

  always_comb begin
    dbr = 17'((dbprod + 40'd8388608) >> 24);
    db_c = peak_zero ? DB_FLOOR_Q88 : -$signed({1'b0, dbr});
    tw = {over, 1'b0};
    kn = {6'b0, cfg.knee_width_db};
    in_knee = (cfg.knee_width_db != '0) && (tw > -kn) && (tw < kn);
    hard = (tw >= kn);
    hard_prod = cfg.ratio_slope * over[16:0];
    gr_hard = 15'(({1'b0, hard_prod} + 34'd32768) >> 16);
    gr8 = {1'b0, gr, 8'b0};
    up_c = gr8 > env;
    diff_c = up_c ? (gr8 - env) : (env - gr8);
    delta = ENV_W'((49'(envprod) + 49'd8388608) >> 24);
    g = $signed({{4{cfg.makeup_db[13]}}, cfg.makeup_db, 8'b0}) - $signed({2'b0, env});
    gmag = g[25] ? 25'(-g) : 25'(g);
    magr = 23'((gprod + 47'd8388608) >> 24);
    e = gneg ? -$signed({1'b0, magr}) : $signed({1'b0, magr});
    shift_c = 9'sd30 - $signed(e[23:16]);
    exp_prod = {31'b0, em} * {32'b0, EXP_ROOT[step]};
    exp_next = 32'((exp_prod + 63'h2000_0000) >> 30);
    av = rd_data[23] ? (~rd_data + 1'b1) : rd_data;
    round_sum = {8'b0, sprod} + (64'd1 << (shamt - 7'd1));
    qv = round_sum >> shamt;
    if (sneg) begin
      res = (qv > 64'd8388608) ? 24'h800000 : -qv[23:0];
    end else begin
      res = (qv > 64'd8388607) ? 24'h7FFFFF : qv[23:0];
    end
  end

  assign load = (state == ST_OUT) && (!out_valid || out_ready);
  assign last = (idx == q_head.count - 1'b1);
  assign q_pop = load && last;
  assign rd_idx = idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      idx <= '0;
      env <= '0;
      rd_bank <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sample_out <= res;
        frame_last_out <= last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            peak_zero <= (q_head.peak == '0);
            k <= k_c;
            m <= m_init;
            frac <= '0;
            step <= '0;
            state <= ST_LOG;
          end
        end
        ST_LOG: begin
          if (sqs[31]) begin
            m <= sqs[31:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m <= sqs[30:0];
            frac <= {frac[14:0], 1'b0};
          end
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= ST_DBMUL;
          end
        end
        ST_DBMUL: begin
          dbprod <= 40'(neg_c) * 40'(K_DB_PER_LOG2);
          state <= ST_DB;
        end
        ST_DB: begin
          over <= db_c - $signed({{3{cfg.threshold_db[14]}}, cfg.threshold_db});
          state <= ST_GR;
        end
        ST_GR: begin
          if (in_knee) begin
            t2 <= 14'(tw + kn);
            p1 <= cfg.ratio_slope * 14'(tw + kn);
            state <= ST_SQ;
          end else begin
            gr <= hard ? gr_hard : '0;
            state <= ST_ENV;
          end
        end
        ST_SQ: begin
          rem <= 45'(p1) * 45'(t2) + {14'b0, cfg.knee_width_db, 18'b0};
          dsh <= {1'b0, cfg.knee_width_db, 31'b0};
          quot <= '0;
          step <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quot <= {quot[11:0], 1'b1};
          end else begin
            quot <= {quot[11:0], 1'b0};
          end
          dsh <= dsh >> 1;
          step <= step + 4'd1;
          if (step == 4'd12) begin
            state <= ST_ENV;
          end
        end
        ST_ENV: begin
          if (step == 4'd13) begin
            gr <= {2'b0, quot};
          end
          state <= ST_ENV2;
        end
        ST_ENV2: begin
          if (step == 4'd13) begin
            step <= '0;
          end else begin
            up <= up_c;
            envprod <= diff_c * (up_c ? cfg.attack_coefficient : cfg.release_coefficient);
            state <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          env <= up ? (env + delta) : (env - delta);
          state <= ST_EXPS;
        end
        ST_EXPS: begin
          gneg <= g[25];
          gprod <= 47'(gmag) * 47'(K_LOG2_PER_DB);
          step <= '0;
          exp_seed <= 1'b1;
          state <= ST_EXP;
        end
        ST_EXP: begin
          if (exp_seed) begin
            // First cycle: split the exponent and seed the product.
            mf <= e[15:0];
            shamt <= shift_c[6:0];
            em <= 32'h4000_0000;
            exp_seed <= 1'b0;
          end else begin
            if (mf[4'd15 - step]) begin
              em <= exp_next;
            end
            step <= step + 4'd1;
            if (step == 4'd15) begin
              idx <= '0;
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          sneg <= rd_data[23];
          sprod <= 56'(av) * 56'(em);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (load) begin
            if (last) begin
              rd_bank <= !rd_bank;
              step <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_knee: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cfg.knee_width_db != '0))
    else $error("soft-knee division entered with a hard knee");

  a_pop_shows_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (out_valid && frame_last_out))
    else $error("frame released without its last sample on the output");

  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (idx < q_head.count))
    else $error("sample index ran past the frame");

endmodule
